/* rtl/ssl_pkg.sv */
// ----------------------------------------------------------------------------
// ssl_pkg
// Shared types, constants and the microcode program of the seat session
// sample logger.
// ----------------------------------------------------------------------------
package ssl_pkg;

    localparam int SSL_SLOTS      = 4;
    localparam int SSL_STEP_W     = 4;
    localparam int SSL_CFG_IDX_W  = 2;
    localparam int SSL_CFG_DATA_W = 16;

    localparam logic [7:0]  SSL_THRESH_RST  = 8'd240;
    localparam logic [15:0] SSL_MIN_DUR_RST = 16'd1;
    localparam logic        SSL_LINK_RST    = 1'b1;

    typedef enum logic [1:0] {
        CMD_PROXIMITY = 2'd0,
        CMD_CONTACT   = 2'd1,
        CMD_SAMPLE    = 2'd2,
        CMD_TICK      = 2'd3
    } t_cmd;

    typedef enum logic [SSL_CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_MIN_DUR   = 2'd1,
        REG_LINK      = 2'd2
    } t_reg;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_TICK,
        OP_IDX_CLR,
        OP_LOAD_PREV,
        OP_AVG,
        OP_WR_NEW,
        OP_EMIT_LO,
        OP_EMIT_HI,
        OP_EMIT_T,
        OP_EMIT_L,
        OP_CLEAR
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_STORE,
        C_NOT_FULL,
        C_AVG_MORE,
        C_NO_END,
        C_NO_EMIT,
        C_NO_SAMPLES,
        C_MORE_SAMPLES
    } t_cond;

    typedef enum logic [1:0] {
        H_NONE,
        H_IN,
        H_OUT
    } t_hold;

    typedef struct packed {
        t_op                   op;
        t_cond                 cond;
        t_hold                 hold;
        logic [SSL_STEP_W-1:0] target;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        t_op  op;
        logic fire;
    } t_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic out_busy;
        logic no_store;
        logic not_full;
        logic avg_more;
        logic no_end;
        logic no_emit;
        logic no_samples;
        logic more_samples;
    } t_status;

    localparam logic [SSL_STEP_W-1:0] ST_IDLE    = 4'd0;
    localparam logic [SSL_STEP_W-1:0] ST_AVG_RD  = 4'd5;
    localparam logic [SSL_STEP_W-1:0] ST_WR_NEW  = 4'd7;
    localparam logic [SSL_STEP_W-1:0] ST_ENDCHK  = 4'd8;
    localparam logic [SSL_STEP_W-1:0] ST_SMP_RD  = 4'd12;
    localparam logic [SSL_STEP_W-1:0] ST_CLEAR   = 4'd15;

    // microcode program
    function automatic t_uword ssl_ucode(input logic [SSL_STEP_W-1:0] step);
        t_uword w;
        w = '{op: OP_NOP, cond: C_NEVER, hold: H_NONE, target: ST_IDLE};
        case (step)
            4'd0:  w = '{op: OP_ACCEPT,    cond: C_NEVER,        hold: H_IN,   target: ST_IDLE};
            4'd1:  w = '{op: OP_TICK,      cond: C_NO_STORE,     hold: H_NONE, target: ST_ENDCHK};
            4'd2:  w = '{op: OP_IDX_CLR,   cond: C_NOT_FULL,     hold: H_NONE, target: ST_WR_NEW};
            4'd3:  w = '{op: OP_NOP,       cond: C_NEVER,        hold: H_NONE, target: ST_IDLE};
            4'd4:  w = '{op: OP_LOAD_PREV, cond: C_NEVER,        hold: H_NONE, target: ST_IDLE};
            4'd5:  w = '{op: OP_NOP,       cond: C_NEVER,        hold: H_NONE, target: ST_IDLE};
            4'd6:  w = '{op: OP_AVG,       cond: C_AVG_MORE,     hold: H_NONE, target: ST_AVG_RD};
            4'd7:  w = '{op: OP_WR_NEW,    cond: C_NEVER,        hold: H_NONE, target: ST_IDLE};
            4'd8:  w = '{op: OP_NOP,       cond: C_NO_END,       hold: H_NONE, target: ST_IDLE};
            4'd9:  w = '{op: OP_NOP,       cond: C_NO_EMIT,      hold: H_NONE, target: ST_CLEAR};
            4'd10: w = '{op: OP_EMIT_LO,   cond: C_NEVER,        hold: H_OUT,  target: ST_IDLE};
            4'd11: w = '{op: OP_EMIT_HI,   cond: C_NO_SAMPLES,   hold: H_OUT,  target: ST_CLEAR};
            4'd12: w = '{op: OP_NOP,       cond: C_NEVER,        hold: H_NONE, target: ST_IDLE};
            4'd13: w = '{op: OP_EMIT_T,    cond: C_NEVER,        hold: H_OUT,  target: ST_IDLE};
            4'd14: w = '{op: OP_EMIT_L,    cond: C_MORE_SAMPLES, hold: H_OUT,  target: ST_SMP_RD};
            4'd15: w = '{op: OP_CLEAR,     cond: C_ALWAYS,       hold: H_NONE, target: ST_IDLE};
            default: w = '{op: OP_NOP, cond: C_ALWAYS, hold: H_NONE, target: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* rtl/ssl_ram.sv */
// ----------------------------------------------------------------------------
// ssl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ssl_seq.sv */
// ----------------------------------------------------------------------------
// ssl_seq
// Microcode sequencer: step counter, program ROM, hold and jump logic.
// ----------------------------------------------------------------------------
module ssl_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  ssl_pkg::t_status i_status,
    output logic            o_in_ready,
    output ssl_pkg::t_ctrl  o_ctrl
);
    import ssl_pkg::*;

    logic [SSL_STEP_W-1:0] r_step;
    logic [SSL_STEP_W-1:0] n_step;
    t_uword                uw;
    logic                  held;
    logic                  jump;

    assign uw = ssl_ucode(r_step);

    always_comb begin
        case (uw.hold)
            H_IN:    held = !i_in_valid;
            H_OUT:   held = i_status.out_busy;
            default: held = 1'b0;
        endcase

        case (uw.cond)
            C_ALWAYS:       jump = 1'b1;
            C_NO_STORE:     jump = i_status.no_store;
            C_NOT_FULL:     jump = i_status.not_full;
            C_AVG_MORE:     jump = i_status.avg_more;
            C_NO_END:       jump = i_status.no_end;
            C_NO_EMIT:      jump = i_status.no_emit;
            C_NO_SAMPLES:   jump = i_status.no_samples;
            C_MORE_SAMPLES: jump = i_status.more_samples;
            default:        jump = 1'b0;
        endcase

        if (held) begin
            n_step = r_step;
        end else if (jump) begin
            n_step = uw.target;
        end else begin
            n_step = r_step + SSL_STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_in_ready  = (uw.hold == H_IN);
    assign o_ctrl.op   = uw.op;
    assign o_ctrl.fire = !held;

endmodule

/* rtl/ssl_datapath.sv */
// ----------------------------------------------------------------------------
// ssl_datapath
// Session state, configuration registers, sample store and output register.
// ----------------------------------------------------------------------------
module ssl_datapath #(
    parameter int SAMPLE_SLOTS = ssl_pkg::SSL_SLOTS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ssl_pkg::t_ctrl                     i_ctrl,
    output ssl_pkg::t_status                   o_status,
    input  logic                               i_cfg_we,
    input  logic [ssl_pkg::SSL_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ssl_pkg::SSL_CFG_DATA_W-1:0] i_cfg_data,
    input  logic [1:0]                         i_command,
    input  logic [7:0]                         i_proximity,
    input  logic                               i_flex_present,
    input  logic                               i_ir_present,
    input  logic [7:0]                         i_temperature,
    input  logic [7:0]                         i_light,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [7:0]                         o_payload_byte,
    output logic                               o_last_byte
);
    import ssl_pkg::*;

    localparam int IW = $clog2(SAMPLE_SLOTS);
    localparam int CW = IW + 1;

    // configuration
    logic [7:0]  r_thresh;
    logic [15:0] r_min_dur;
    logic        r_link;

    // session state
    logic          r_seated, n_seated;
    logic          r_flex, n_flex;
    logic          r_ir, n_ir;
    logic          r_prox, n_prox;
    logic [15:0]   r_seconds, n_seconds;
    logic [CW-1:0] r_count, n_count;
    t_cmd          r_cmd, n_cmd;
    logic [15:0]   r_sample, n_sample;
    logic [IW-1:0] r_idx, n_idx;
    logic [15:0]   r_prev, n_prev;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_last, n_out_last;

    // store
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic [15:0]   ram_rdata;
    logic [8:0]    avg_t;
    logic [8:0]    avg_l;
    logic          full;
    logic          more_samples;

    ssl_ram #(
        .WIDTH (16),
        .DEPTH (SAMPLE_SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign full         = (r_count == CW'(SAMPLE_SLOTS));
    assign more_samples = ((CW'(r_idx) + CW'(1)) != r_count);
    assign avg_t = ({1'b0, r_prev[15:8]} + {1'b0, ram_rdata[15:8]});
    assign avg_l = ({1'b0, r_prev[7:0]} + {1'b0, ram_rdata[7:0]});

    always_comb begin
        o_status.out_busy     = r_out_valid && !i_out_ready;
        o_status.no_store     = !(r_seated && (r_cmd == CMD_SAMPLE));
        o_status.not_full     = !full;
        o_status.avg_more     = (r_idx != IW'(SAMPLE_SLOTS - 1));
        o_status.no_end       = !(r_seated && !r_flex && !r_ir && !r_prox);
        o_status.no_emit      = !((r_seconds >= r_min_dur) && r_link);
        o_status.no_samples   = (r_count == '0);
        o_status.more_samples = more_samples;
    end

    always_comb begin
        n_seated    = r_seated;
        n_flex      = r_flex;
        n_ir        = r_ir;
        n_prox      = r_prox;
        n_seconds   = r_seconds;
        n_count     = r_count;
        n_cmd       = r_cmd;
        n_sample    = r_sample;
        n_idx       = r_idx;
        n_prev      = r_prev;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        ram_we      = 1'b0;
        ram_waddr   = r_idx - IW'(1);
        ram_wdata   = {avg_t[8:1], avg_l[8:1]};

        if (i_ctrl.fire) begin
            case (i_ctrl.op)
                OP_ACCEPT: begin
                    n_cmd    = t_cmd'(i_command);
                    n_sample = {i_temperature, i_light};
                    if (t_cmd'(i_command) == CMD_PROXIMITY) begin
                        n_prox = (i_proximity <= r_thresh);
                    end else if (t_cmd'(i_command) == CMD_CONTACT) begin
                        n_flex = i_flex_present;
                        n_ir   = i_ir_present;
                    end
                    // session starts on any present flag
                    if ((n_prox || n_flex || n_ir) && !r_seated) begin
                        n_seated  = 1'b1;
                        n_seconds = '0;
                    end
                end
                OP_TICK: begin
                    if (r_seated && (r_cmd == CMD_TICK)) begin
                        n_seconds = r_seconds + 16'd1;
                    end
                end
                OP_IDX_CLR: begin
                    n_idx = '0;
                end
                OP_LOAD_PREV: begin
                    n_prev = ram_rdata;
                    n_idx  = r_idx + IW'(1);
                end
                OP_AVG: begin
                    // slot idx-1 takes the mean of itself and slot idx
                    ram_we = 1'b1;
                    n_prev = ram_rdata;
                    n_idx  = r_idx + IW'(1);
                end
                OP_WR_NEW: begin
                    ram_we    = 1'b1;
                    ram_wdata = r_sample;
                    if (full) begin
                        ram_waddr = IW'(SAMPLE_SLOTS - 1);
                    end else begin
                        ram_waddr = r_count[IW-1:0];
                        n_count   = r_count + CW'(1);
                    end
                end
                OP_EMIT_LO: begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_seconds[7:0];
                    n_out_last  = 1'b0;
                end
                OP_EMIT_HI: begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_seconds[15:8];
                    n_out_last  = (r_count == '0);
                    n_idx       = '0;
                end
                OP_EMIT_T: begin
                    n_out_valid = 1'b1;
                    n_out_byte  = ram_rdata[15:8];
                    n_out_last  = 1'b0;
                end
                OP_EMIT_L: begin
                    n_out_valid = 1'b1;
                    n_out_byte  = ram_rdata[7:0];
                    n_out_last  = !more_samples;
                    n_idx       = r_idx + IW'(1);
                end
                OP_CLEAR: begin
                    n_seated  = 1'b0;
                    n_seconds = '0;
                    n_count   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh    <= SSL_THRESH_RST;
            r_min_dur   <= SSL_MIN_DUR_RST;
            r_link      <= SSL_LINK_RST;
            r_seated    <= 1'b0;
            r_flex      <= 1'b0;
            r_ir        <= 1'b0;
            r_prox      <= 1'b0;
            r_seconds   <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_idx))
                    REG_THRESHOLD: r_thresh  <= i_cfg_data[7:0];
                    REG_MIN_DUR:   r_min_dur <= i_cfg_data[15:0];
                    REG_LINK:      r_link    <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            r_seated    <= n_seated;
            r_flex      <= n_flex;
            r_ir        <= n_ir;
            r_prox      <= n_prox;
            r_seconds   <= n_seconds;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_sample   <= n_sample;
        r_prev     <= n_prev;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_out_byte;
    assign o_last_byte    = r_out_last;

endmodule

/* rtl/seat_session_sample_logger_core.sv */
// ----------------------------------------------------------------------------
// seat_session_sample_logger_core
// Seat occupancy session logger with sample store and byte payload output.
// ----------------------------------------------------------------------------
// One event is taken at a time; a small microcode program steps through its
// work, one control word per clock while no step is held by the input or
// output handshake. A proximity, contact or tick event, or a sample taken
// while the seat is empty, passes the accept, tick and end-check steps. A
// stored sample adds an index-clear and a write step and, once the store is
// full, an averaging pass in between with a read step and an averaging step
// per slot, since the sample RAM has registered read data. At a session end
// a further step decides on the payload, which then leaves as two duration
// beats plus two beats per stored sample; a last step clears the session.
// ----------------------------------------------------------------------------
module seat_session_sample_logger_core #(
    parameter int SAMPLE_SLOTS = ssl_pkg::SSL_SLOTS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ssl_pkg::SSL_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ssl_pkg::SSL_CFG_DATA_W-1:0] i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_command,
    input  logic [7:0]                         i_proximity,
    input  logic                               i_flex_present,
    input  logic                               i_ir_present,
    input  logic [7:0]                         i_temperature,
    input  logic [7:0]                         i_light,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [7:0]                         o_payload_byte,
    output logic                               o_last_byte
);
    import ssl_pkg::*;

    t_ctrl   ctrl;
    t_status status;

    ssl_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_ctrl     (ctrl)
    );

    ssl_datapath #(
        .SAMPLE_SLOTS (SAMPLE_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_proximity    (i_proximity),
        .i_flex_present (i_flex_present),
        .i_ir_present   (i_ir_present),
        .i_temperature  (i_temperature),
        .i_light        (i_light),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_payload_byte (o_payload_byte),
        .o_last_byte    (o_last_byte)
    );

endmodule
